// ===== src/assert_macros.svh =====
// Assertion helpers, included by tile_average_binarizer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tab_pkg.sv =====
`default_nettype none

package tab_pkg;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int TS_W       = 7;
    localparam int TA_W       = 8;
    localparam int THR_W      = 8;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 7;
    localparam int PIT_W      = 6;
    localparam int RIT_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Sizes
    localparam int MAX_TILE_SIZE    = 64;
    localparam int MAX_TILES_ACROSS = 128;
    localparam int MAX_TILES_DOWN   = 128;
    localparam int NUM_CH           = 3;
    localparam int CH_W             = 2;

    // Sums and division
    localparam int SUM_W  = 20;
    localparam int N_W    = 13;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int MEAN_W = SUM_W + 2;
    localparam int LIM_W  = THR_W + 2;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Register reset values
    localparam logic [TS_W-1:0]  TILE_SIZE_RST    = TS_W'(10);
    localparam logic [TA_W-1:0]  TILES_ACROSS_RST = TA_W'(73);
    localparam logic [TA_W-1:0]  TILES_DOWN_RST   = TA_W'(73);
    localparam logic [THR_W-1:0] THRESHOLD_RST    = THR_W'(150);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_SIZE,
        REG_TILES_ACROSS,
        REG_TILES_DOWN,
        REG_THRESHOLD
    } cfg_reg_t;

    typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_t;
    typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DIV_START,
        S_DIV_WAIT,
        S_FINISH
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic acc;
        logic div_start;
        logic div_take;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic tile_done;
        logic div_busy;
        logic div_done;
        logic last_ch;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/tab_if.sv =====
`default_nettype none

// Pixel channel
interface tab_pix_if;
    logic                      valid;
    logic                      ready;
    logic [tab_pkg::PIX_W-1:0] red;
    logic [tab_pkg::PIX_W-1:0] green;
    logic [tab_pkg::PIX_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// Tile result channel
interface tab_tile_if;
    logic                      valid;
    logic                      ready;
    logic [tab_pkg::COL_W-1:0] tile_col;
    logic [tab_pkg::ROW_W-1:0] tile_row;
    logic                      lit;
    logic                      last_of_frame;

    modport source (output valid, tile_col, tile_row, lit, last_of_frame, input ready);
    modport sink   (input valid, tile_col, tile_row, lit, last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== src/tile_average_binarizer.sv =====
// Tile average binarizer. Pixels arrive in raster order on the pix channel; the
// frame is tiles_across by tiles_down square tiles of tile_size pixels. Per tile
// column of the current tile row the block keeps red, green and blue sums in a
// 128-entry RAM. On a tile's last pixel each sum is divided by tile_size squared,
// and one beat leaves on the tile channel with lit set when the average of the
// three means exceeds threshold. Pixels are taken one at a time: an ordinary
// pixel is accepted, then the sums of its column get a read-modify-write. A
// pixel that completes a tile then has each of the three channels divided in
// turn by the shared serial divider, in 20 steps per channel. A finished beat
// sits in an output register, so the next pixel is taken while it waits.
// Reset clears the sums at once, with no sweep. The user must write registers
// through cfg_we / cfg_index / cfg_data only while no pixel is in progress;
// the block itself does not enforce it.
`default_nettype none

`include "assert_macros.svh"

module tile_average_binarizer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    tab_pix_if.sink                             pix,
    tab_tile_if.source                          tile,
    input  wire logic                           cfg_we,
    input  wire logic [tab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tab_pkg::CFG_DATA_W-1:0] cfg_data
);

    tab_pkg::cmd_t  cmd;
    tab_pkg::stat_t stat;
    tab_pkg::pix_t  pix_data;
    logic           in_ready;

    assign pix_data  = {pix.red, pix.green, pix.blue};
    assign pix.ready = in_ready;

    // Sequencer
    tab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Counters, sums, divider and output register
    tab_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_data  (pix_data),
        .out_ready (tile.ready),
        .out_valid (tile.valid),
        .out_col   (tile.tile_col),
        .out_row   (tile.tile_row),
        .out_lit   (tile.lit),
        .out_last  (tile.last_of_frame)
    );

    // One pixel in flight at a time
    `ASSERT_NEXT(a_one_pixel, clk, rst_n, pix.valid && pix.ready, !pix.ready, "pixel accepted while busy")
    // Divider is never restarted mid-division
    `ASSERT_IMPL(a_div_free, clk, rst_n, cmd.div_start, !stat.div_busy, "divider restarted while busy")
    // A waiting result is never overwritten
    `ASSERT_IMPL(a_out_slot, clk, rst_n, cmd.load_out, !tile.valid || tile.ready, "result beat overwritten")

endmodule

`default_nettype wire

// ===== src/tab_ram.sv =====
`default_nettype none

module tab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/tab_div.sv =====
`default_nettype none

module tab_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tab_pkg::SUM_W-1:0]   dividend,
    input  wire logic [tab_pkg::N_W-1:0]     divisor,
    output logic                             busy,
    output logic                             done,
    output logic      [tab_pkg::SUM_W-1:0]   quotient
);

    logic [tab_pkg::N_W-1:0]    rem_reg;
    logic [tab_pkg::SUM_W-1:0]  quo_reg;
    logic [tab_pkg::N_W-1:0]    dvs_reg;
    logic [tab_pkg::STEP_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [tab_pkg::N_W:0] trial;
    logic [tab_pkg::N_W:0] diff;
    logic                  fits;

    // Restoring step: one quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[tab_pkg::SUM_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= tab_pkg::STEP_W'(tab_pkg::SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - tab_pkg::STEP_W'(1);
                if (cnt_reg == tab_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[tab_pkg::N_W-1:0] : trial[tab_pkg::N_W-1:0];
            quo_reg <= {quo_reg[tab_pkg::SUM_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/tab_ctrl.sv =====
`default_nettype none

module tab_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire tab_pkg::stat_t stat,
    output tab_pkg::cmd_t       cmd
);

    tab_pkg::ctrl_state_t state_reg;
    tab_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tab_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            tab_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = tab_pkg::S_ACC;
                end
            end
            tab_pkg::S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = stat.tile_done ? tab_pkg::S_DIV_START : tab_pkg::S_IDLE;
            end
            tab_pkg::S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = tab_pkg::S_DIV_WAIT;
            end
            tab_pkg::S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = stat.last_ch ? tab_pkg::S_FINISH : tab_pkg::S_DIV_START;
                end
            end
            tab_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = tab_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tab_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/tab_dp.sv =====
`default_nettype none

module tab_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tab_pkg::cmd_t                    cmd,
    output tab_pkg::stat_t                        stat,
    input  wire logic                             cfg_we,
    input  wire logic [tab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tab_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire tab_pkg::pix_t                    pix_data,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic      [tab_pkg::COL_W-1:0]        out_col,
    output logic      [tab_pkg::ROW_W-1:0]        out_row,
    output logic                                  out_lit,
    output logic                                  out_last
);

    // Configuration registers
    logic [tab_pkg::TS_W-1:0]  tile_size_reg;
    logic [tab_pkg::TA_W-1:0]  tiles_across_reg;
    logic [tab_pkg::TA_W-1:0]  tiles_down_reg;
    logic [tab_pkg::THR_W-1:0] threshold_reg;

    // Raster counters
    logic [tab_pkg::PIT_W-1:0] pit_reg, pit_next;
    logic [tab_pkg::COL_W-1:0] col_reg, col_next;
    logic [tab_pkg::RIT_W-1:0] rit_reg, rit_next;
    logic [tab_pkg::ROW_W-1:0] rot_reg, rot_next;

    logic [tab_pkg::MAX_TILES_ACROSS-1:0] col_valid_reg;

    tab_pkg::pix_t  pix_reg;
    tab_pkg::sums_t ram_rdata;
    tab_pkg::sums_t old_sums;
    tab_pkg::sums_t new_sums;
    tab_pkg::sums_t div_sums_reg;
    logic [tab_pkg::NUM_CH-1:0][tab_pkg::SUM_W:0] sum_wide;

    logic [tab_pkg::TS_W-1:0] ts_c;
    logic [tab_pkg::TA_W-1:0] ta_c;
    logic [tab_pkg::TA_W-1:0] td_c;
    logic                     pit_wrap, rit_wrap, col_wrap, rot_wrap;
    logic                     tile_done;
    logic [2*tab_pkg::TS_W-1:0] n_full;

    logic [tab_pkg::CH_W-1:0]   ch_reg;
    logic [tab_pkg::MEAN_W-1:0] mean_reg;
    logic [tab_pkg::LIM_W-1:0]  thr_ext, lim;

    logic [tab_pkg::COL_W-1:0] hold_col_reg;
    logic [tab_pkg::ROW_W-1:0] hold_row_reg;
    logic                      hold_last_reg;

    logic                      out_valid_reg;
    logic [tab_pkg::COL_W-1:0] out_col_reg;
    logic [tab_pkg::ROW_W-1:0] out_row_reg;
    logic                      out_lit_reg;
    logic                      out_last_reg;

    logic                       div_busy, div_done;
    logic [tab_pkg::SUM_W-1:0]  quotient;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_size_reg    <= tab_pkg::TILE_SIZE_RST;
            tiles_across_reg <= tab_pkg::TILES_ACROSS_RST;
            tiles_down_reg   <= tab_pkg::TILES_DOWN_RST;
            threshold_reg    <= tab_pkg::THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (tab_pkg::cfg_reg_t'(cfg_index))
                tab_pkg::REG_TILE_SIZE:    tile_size_reg    <= cfg_data[tab_pkg::TS_W-1:0];
                tab_pkg::REG_TILES_ACROSS: tiles_across_reg <= cfg_data;
                tab_pkg::REG_TILES_DOWN:   tiles_down_reg   <= cfg_data;
                tab_pkg::REG_THRESHOLD:    threshold_reg    <= cfg_data;
                default:                   tile_size_reg    <= tile_size_reg;
            endcase
        end
    end

    // Clamped sizes: zero acts as one, oversize saturates
    always_comb
    begin
        if (tile_size_reg == '0)
            ts_c = tab_pkg::TS_W'(1);
        else if (tile_size_reg > tab_pkg::TS_W'(tab_pkg::MAX_TILE_SIZE))
            ts_c = tab_pkg::TS_W'(tab_pkg::MAX_TILE_SIZE);
        else
            ts_c = tile_size_reg;

        if (tiles_across_reg == '0)
            ta_c = tab_pkg::TA_W'(1);
        else if (tiles_across_reg > tab_pkg::TA_W'(tab_pkg::MAX_TILES_ACROSS))
            ta_c = tab_pkg::TA_W'(tab_pkg::MAX_TILES_ACROSS);
        else
            ta_c = tiles_across_reg;

        if (tiles_down_reg == '0)
            td_c = tab_pkg::TA_W'(1);
        else if (tiles_down_reg > tab_pkg::TA_W'(tab_pkg::MAX_TILES_DOWN))
            td_c = tab_pkg::TA_W'(tab_pkg::MAX_TILES_DOWN);
        else
            td_c = tiles_down_reg;
    end

    // Wrap conditions and raster advance
    always_comb
    begin
        pit_wrap  = (tab_pkg::TS_W'(pit_reg) + tab_pkg::TS_W'(1)) >= ts_c;
        rit_wrap  = (tab_pkg::TS_W'(rit_reg) + tab_pkg::TS_W'(1)) >= ts_c;
        col_wrap  = (tab_pkg::TA_W'(col_reg) + tab_pkg::TA_W'(1)) >= ta_c;
        rot_wrap  = (tab_pkg::TA_W'(rot_reg) + tab_pkg::TA_W'(1)) >= td_c;
        tile_done = pit_wrap && rit_wrap;

        pit_next = pit_reg;
        col_next = col_reg;
        rit_next = rit_reg;
        rot_next = rot_reg;
        if (!pit_wrap)
        begin
            pit_next = pit_reg + tab_pkg::PIT_W'(1);
        end
        else
        begin
            pit_next = '0;
            if (!col_wrap)
            begin
                col_next = col_reg + tab_pkg::COL_W'(1);
            end
            else
            begin
                col_next = '0;
                if (!rit_wrap)
                begin
                    rit_next = rit_reg + tab_pkg::RIT_W'(1);
                end
                else
                begin
                    rit_next = '0;
                    rot_next = rot_wrap ? '0 : rot_reg + tab_pkg::ROW_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pit_reg <= '0;
            col_reg <= '0;
            rit_reg <= '0;
            rot_reg <= '0;
        end
        else if (cmd.acc)
        begin
            pit_reg <= pit_next;
            col_reg <= col_next;
            rit_reg <= rit_next;
            rot_reg <= rot_next;
        end
    end

    // Column sums: never-written or cleared columns read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_valid_reg <= '0;
        end
        else if (cmd.acc)
        begin
            col_valid_reg[col_reg] <= !tile_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg <= pix_data;
        end
    end

    tab_ram #(
        .WIDTH ($bits(tab_pkg::sums_t)),
        .DEPTH (tab_pkg::MAX_TILES_ACROSS)
    ) u_sum_ram (
        .clk   (clk),
        .we    (cmd.acc && !tile_done),
        .waddr (col_reg),
        .wdata (new_sums),
        .re    (cmd.accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // Saturating accumulate
    always_comb
    begin
        old_sums = col_valid_reg[col_reg] ? ram_rdata : '0;
        for (int c = 0; c < tab_pkg::NUM_CH; c++)
        begin
            sum_wide[c] = {1'b0, old_sums[c]} + (tab_pkg::SUM_W + 1)'(pix_reg[c]);
            new_sums[c] = sum_wide[c][tab_pkg::SUM_W] ? tab_pkg::SUM_MAX
                                                      : sum_wide[c][tab_pkg::SUM_W-1:0];
        end
    end

    // Tile finish: latch sums and result position
    always_ff @(posedge clk)
    begin
        if (cmd.acc && tile_done)
        begin
            div_sums_reg  <= new_sums;
            hold_col_reg  <= col_reg;
            hold_row_reg  <= rot_reg;
            hold_last_reg <= col_wrap && rot_wrap;
        end
    end

    // Pixels per tile
    assign n_full = {{tab_pkg::TS_W{1'b0}}, ts_c} * {{tab_pkg::TS_W{1'b0}}, ts_c};

    tab_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_sums_reg[ch_reg]),
        .divisor  (n_full[tab_pkg::N_W-1:0]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // Channel sequencing and mean accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= '0;
        end
        else if (cmd.acc && tile_done)
        begin
            ch_reg <= '0;
        end
        else if (cmd.div_take)
        begin
            ch_reg <= ch_reg + tab_pkg::CH_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc && tile_done)
        begin
            mean_reg <= '0;
        end
        else if (cmd.div_take)
        begin
            mean_reg <= mean_reg + tab_pkg::MEAN_W'(quotient);
        end
    end

    // floor(sum / 3) > thr  <=>  sum >= 3 * thr + 3
    always_comb
    begin
        thr_ext = tab_pkg::LIM_W'(threshold_reg);
        lim     = (thr_ext << 1) + thr_ext + tab_pkg::LIM_W'(3);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_col_reg  <= hold_col_reg;
            out_row_reg  <= hold_row_reg;
            out_last_reg <= hold_last_reg;
            out_lit_reg  <= mean_reg >= tab_pkg::MEAN_W'(lim);
        end
    end

    // Status
    always_comb
    begin
        stat.tile_done = tile_done;
        stat.div_busy  = div_busy;
        stat.div_done  = div_done;
        stat.last_ch   = ch_reg == tab_pkg::CH_W'(tab_pkg::NUM_CH - 1);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign out_lit   = out_lit_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire
